/* hdl/qtl_pkg.sv */
// Shared types, constants and helper functions for the query token lexer.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qtl_pkg;

    // Width of the position, line, column and length counters.
    localparam int POS_BITS      = 16;
    // Longest identifier that can still be a keyword.
    localparam int KEYWORD_CHARS = 8;
    // Width of the positional result fields on the ports.
    localparam int FIELD_W       = 16;
    localparam int KIND_W        = 5;
    localparam int CHAR_W        = 8;
    // Upper-cased identifier bytes kept for keyword matching.
    localparam int WIN_CHARS     = 8;
    localparam int WIN_W         = WIN_CHARS * CHAR_W;

    // Result queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd3;
    localparam logic [KIND_W-1:0] KIND_DOT    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd5;
    localparam logic [KIND_W-1:0] KIND_OPER   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd7;
    localparam logic [KIND_W-1:0] KIND_EOF    = 5'd8;

    // Item function codes.
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Keyword table: upper-cased text right-aligned in the window, its length
    // and the token kind it yields.
    localparam int KW_COUNT = 13;

    localparam logic [WIN_W-1:0] KW_CODE [KW_COUNT] = '{
        64'h454E544954494553,  // ENTITIES
        64'h004841535F414E59,  // HAS_ANY
        64'h004E4F545F484153,  // NOT_HAS
        64'h000053454C454354,  // SELECT
        64'h0000454E54495459,  // ENTITY
        64'h000000434F554E54,  // COUNT
        64'h0000005748455245,  // WHERE
        64'h0000000053484F57,  // SHOW
        64'h0000000000484153,  // HAS
        64'h0000000000414C4C,  // ALL
        64'h0000000000414E44,  // AND
        64'h0000000000004F46,  // OF
        64'h0000000000004F52   // OR
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd7, 4'd7, 4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2
    };

    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
        5'd19, 5'd20, 5'd21
    };

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic               last;
    } token_t;

    // Counter increment that stops at all ones.
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        logic [POS_BITS-1:0] r;
        r = (v == {POS_BITS{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

    // Keyword lookup; an identifier that matches nothing stays an identifier.
    function automatic logic [KIND_W-1:0] kw_kind(input logic [WIN_W-1:0]    win,
                                                  input logic [POS_BITS-1:0] len);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        if (len <= POS_BITS'(WIN_CHARS) && len <= POS_BITS'(KEYWORD_CHARS)) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                if (len == POS_BITS'(KW_LEN[i]) && win == KW_CODE[i]) begin
                    k = KW_KIND[i];
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/qtl_core.sv */
// Lexer state and per-byte scanning: turns one registered item into up to
// two result tokens. Depends on qtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qtl_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic                func,
    input  wire logic [7:0]          ch,
    output logic      [1:0]          res_valid,
    output qtl_pkg::token_t          res0,
    output qtl_pkg::token_t          res1
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_IDENT,
        MODE_OP
    } mode_t;

    mode_t                               mode_reg, mode_next;
    logic [qtl_pkg::POS_BITS-1:0]        tok_off_reg, tok_off_next;
    logic [qtl_pkg::POS_BITS-1:0]        tok_line_reg, tok_line_next;
    logic [qtl_pkg::POS_BITS-1:0]        tok_col_reg, tok_col_next;
    logic [qtl_pkg::POS_BITS-1:0]        tok_len_reg, tok_len_next;
    logic [qtl_pkg::POS_BITS-1:0]        cur_off_reg, cur_off_next;
    logic [qtl_pkg::POS_BITS-1:0]        cur_line_reg, cur_line_next;
    logic [qtl_pkg::POS_BITS-1:0]        cur_col_reg, cur_col_next;
    logic [qtl_pkg::WIN_W-1:0]           win_reg, win_next;

    logic                                is_digit, is_alpha, is_word, is_space, is_opch;
    logic [7:0]                          ch_up;
    logic                                pend;
    logic [qtl_pkg::KIND_W-1:0]          pend_kind;
    qtl_pkg::token_t                     pend_tok, cur_tok;
    logic                                sec_emit;
    qtl_pkg::token_t                     sec_tok;
    logic                                first_emit;
    qtl_pkg::token_t                     first_tok;

    assign is_digit = (ch >= "0") && (ch <= "9");
    assign is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
    assign is_word  = is_alpha || is_digit || (ch == "_");
    assign is_space = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
    assign is_opch  = (ch == ">") || (ch == "<") || (ch == "=") || (ch == "!");
    assign ch_up    = ((ch >= "a") && (ch <= "z")) ? ch - 8'd32 : ch;

    assign pend = (mode_reg != MODE_IDLE);

    always_comb
    begin
        case (mode_reg)
            MODE_NUM:   pend_kind = qtl_pkg::KIND_NUMBER;
            MODE_OP:    pend_kind = qtl_pkg::KIND_OPER;
            MODE_IDENT: pend_kind = qtl_pkg::kw_kind(win_reg, tok_len_reg);
            default:    pend_kind = qtl_pkg::KIND_IDENT;
        endcase
    end

    always_comb
    begin
        pend_tok.kind         = pend_kind;
        pend_tok.start_offset = qtl_pkg::FIELD_W'(tok_off_reg);
        pend_tok.length       = qtl_pkg::FIELD_W'(tok_len_reg);
        pend_tok.line         = qtl_pkg::FIELD_W'(tok_line_reg);
        pend_tok.column       = qtl_pkg::FIELD_W'(tok_col_reg);
        pend_tok.last         = 1'b0;

        // Token that starts and ends at the current position.
        cur_tok.kind         = qtl_pkg::KIND_ERROR;
        cur_tok.start_offset = qtl_pkg::FIELD_W'(cur_off_reg);
        cur_tok.length       = qtl_pkg::FIELD_W'(1);
        cur_tok.line         = qtl_pkg::FIELD_W'(cur_line_reg);
        cur_tok.column       = qtl_pkg::FIELD_W'(cur_col_reg);
        cur_tok.last         = 1'b0;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        tok_off_next  = tok_off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_len_next  = tok_len_reg;
        cur_off_next  = cur_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        win_next      = win_reg;
        first_emit    = 1'b0;
        first_tok     = pend_tok;
        sec_emit      = 1'b0;
        sec_tok       = cur_tok;

        if (go) begin
            if (func == qtl_pkg::FUNC_END) begin
                // Flush the pending token, then EOF at the current position.
                first_emit     = pend;
                sec_emit       = 1'b1;
                sec_tok.kind   = qtl_pkg::KIND_EOF;
                sec_tok.length = '0;
                mode_next      = MODE_IDLE;
                tok_off_next   = '0;
                tok_line_next  = qtl_pkg::POS_BITS'(1);
                tok_col_next   = qtl_pkg::POS_BITS'(1);
                tok_len_next   = '0;
                cur_off_next   = '0;
                cur_line_next  = qtl_pkg::POS_BITS'(1);
                cur_col_next   = qtl_pkg::POS_BITS'(1);
                win_next       = '0;
            end else if (mode_reg == MODE_NUM && is_digit) begin
                tok_len_next = qtl_pkg::sat_inc(tok_len_reg);
                cur_off_next = qtl_pkg::sat_inc(cur_off_reg);
                cur_col_next = qtl_pkg::sat_inc(cur_col_reg);
            end else if (mode_reg == MODE_IDENT && is_word) begin
                tok_len_next = qtl_pkg::sat_inc(tok_len_reg);
                win_next     = {win_reg[qtl_pkg::WIN_W-9:0], ch_up};
                cur_off_next = qtl_pkg::sat_inc(cur_off_reg);
                cur_col_next = qtl_pkg::sat_inc(cur_col_reg);
            end else if (mode_reg == MODE_OP && ch == "=") begin
                // Two-character operator closes at once.
                first_emit       = 1'b1;
                first_tok.length = qtl_pkg::FIELD_W'(2);
                tok_len_next     = qtl_pkg::POS_BITS'(2);
                mode_next        = MODE_IDLE;
                cur_off_next     = qtl_pkg::sat_inc(cur_off_reg);
                cur_col_next     = qtl_pkg::sat_inc(cur_col_reg);
            end else begin
                // Run break: flush whatever is pending, then scan the byte anew.
                first_emit = pend;
                mode_next  = MODE_IDLE;
                if (is_space) begin
                    cur_off_next = qtl_pkg::sat_inc(cur_off_reg);
                    if (ch == 8'd10) begin
                        cur_line_next = qtl_pkg::sat_inc(cur_line_reg);
                        cur_col_next  = qtl_pkg::POS_BITS'(1);
                    end else begin
                        cur_col_next = qtl_pkg::sat_inc(cur_col_reg);
                    end
                end else begin
                    cur_off_next = qtl_pkg::sat_inc(cur_off_reg);
                    cur_col_next = qtl_pkg::sat_inc(cur_col_reg);
                    if (is_opch || is_digit || is_alpha || ch == "_") begin
                        tok_off_next  = cur_off_reg;
                        tok_line_next = cur_line_reg;
                        tok_col_next  = cur_col_reg;
                        tok_len_next  = qtl_pkg::POS_BITS'(1);
                        if (is_opch) begin
                            mode_next = MODE_OP;
                        end else if (is_digit) begin
                            mode_next = MODE_NUM;
                        end else begin
                            mode_next = MODE_IDENT;
                            win_next  = qtl_pkg::WIN_W'(ch_up);
                        end
                    end else begin
                        sec_emit = 1'b1;
                        case (ch)
                            "(":     sec_tok.kind = qtl_pkg::KIND_LPAREN;
                            ")":     sec_tok.kind = qtl_pkg::KIND_RPAREN;
                            ".":     sec_tok.kind = qtl_pkg::KIND_DOT;
                            ",":     sec_tok.kind = qtl_pkg::KIND_COMMA;
                            default: sec_tok.kind = qtl_pkg::KIND_ERROR;
                        endcase
                    end
                end
            end
        end
    end

    // Pack the results into the lower slots and flag the final one.
    always_comb
    begin
        res0      = first_emit ? first_tok : sec_tok;
        res1      = sec_tok;
        res0.last = !(first_emit && sec_emit);
        res1.last = 1'b1;
        res_valid = {first_emit && sec_emit, first_emit || sec_emit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= MODE_IDLE;
            tok_off_reg  <= '0;
            tok_line_reg <= qtl_pkg::POS_BITS'(1);
            tok_col_reg  <= qtl_pkg::POS_BITS'(1);
            tok_len_reg  <= '0;
            cur_off_reg  <= '0;
            cur_line_reg <= qtl_pkg::POS_BITS'(1);
            cur_col_reg  <= qtl_pkg::POS_BITS'(1);
            win_reg      <= '0;
        end else begin
            mode_reg     <= mode_next;
            tok_off_reg  <= tok_off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_len_reg  <= tok_len_next;
            cur_off_reg  <= cur_off_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            win_reg      <= win_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/qtl_out_fifo.sv */
// Result queue: takes up to two tokens per cycle, hands out one per cycle while
// the reader does not stall. Depends on qtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qtl_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push,
    input  qtl_pkg::token_t       din0,
    input  qtl_pkg::token_t       din1,
    output logic                  room,
    output logic                  valid,
    input  wire logic             stall,
    output qtl_pkg::token_t       dout
);

    qtl_pkg::token_t                 entry_reg [qtl_pkg::OQ_DEPTH];
    logic [qtl_pkg::OQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [qtl_pkg::OQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [qtl_pkg::OQ_CNT_W-1:0]    count_reg, count_next;
    logic [qtl_pkg::OQ_PTR_W-1:0]    wr_ptr_b;
    logic                            pop;
    logic [1:0]                      push_n;

    assign valid    = (count_reg != '0);
    assign dout     = entry_reg[rd_ptr_reg];
    assign pop      = valid && !stall;
    // Room for a full pair of results, whatever the reader does.
    assign room     = (count_reg <= qtl_pkg::OQ_CNT_W'(qtl_pkg::OQ_DEPTH - 2));
    assign push_n   = {1'b0, push[0]} + {1'b0, push[1]};
    assign wr_ptr_b = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + qtl_pkg::OQ_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + qtl_pkg::OQ_PTR_W'(pop);
        count_next  = count_reg + qtl_pkg::OQ_CNT_W'(push_n) - qtl_pkg::OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push[0]) begin
            entry_reg[wr_ptr_reg] <= din0;
        end
        if (push[1]) begin
            entry_reg[wr_ptr_b] <= din1;
        end
    end

endmodule

`default_nettype wire

/* hdl/query_token_lexer.sv */
// Top level of the query token lexer: input register, scanning core and
// result queue. Depends on qtl_pkg, qtl_core and qtl_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   func, ch
// output    out        out_valid / out_stall token_kind, start_offset, token_length,
//                                            start_line, start_column, last
//
// An item is taken into the input register and is scanned from there once the
// queue has room; the scan writes its zero, one or two tokens into a four-entry
// result queue, and the head of the queue is offered on the output channel.
// The block takes one item per cycle as long as items give at most one token
// each and the output is not stalled; items that give two tokens can fill the
// queue and stall the input, since the queue hands out one token per cycle.
// Reset clears the lexer state to line one, column one, offset zero, and
// empties the queue. in_stall rises only when the input register holds an
// item and the queue cannot take a full pair of tokens.

module query_token_lexer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          func,
    input  wire logic [qtl_pkg::CHAR_W-1:0]    ch,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [qtl_pkg::KIND_W-1:0]         token_kind,
    output logic [qtl_pkg::FIELD_W-1:0]        start_offset,
    output logic [qtl_pkg::FIELD_W-1:0]        token_length,
    output logic [qtl_pkg::FIELD_W-1:0]        start_line,
    output logic [qtl_pkg::FIELD_W-1:0]        start_column,
    output logic                               last
);

    // Input register.
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_func_reg;
    logic [qtl_pkg::CHAR_W-1:0]     s1_ch_reg;

    logic                           room;
    logic                           go;
    logic                           in_accept;
    logic [1:0]                     res_valid;
    qtl_pkg::token_t                res0, res1, head;

    // The registered item is scanned once the queue can absorb both of the
    // tokens it might produce.
    assign go        = s1_valid_reg && room;
    assign in_stall  = s1_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload is loaded only on acceptance, so it holds while stalled.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_func_reg <= func;
            s1_ch_reg   <= ch;
        end
    end

    qtl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .func      (s1_func_reg),
        .ch        (s1_ch_reg),
        .res_valid (res_valid),
        .res0      (res0),
        .res1      (res1)
    );

    qtl_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din0  (res0),
        .din1  (res1),
        .room  (room),
        .valid (out_valid),
        .stall (out_stall),
        .dout  (head)
    );

    assign token_kind   = head.kind;
    assign start_offset = head.start_offset;
    assign token_length = head.length;
    assign start_line   = head.line;
    assign start_column = head.column;
    assign last         = head.last;

endmodule

`default_nettype wire

/* sim/query_token_lexer_tb.sv */
// Self-checking testbench for query_token_lexer: random and directed query text
// with a token predictor. Depends on qtl_pkg and the query_token_lexer RTL.
`timescale 1ns / 1ps

module query_token_lexer_tb;

    // Kinds given to identifiers that spell one of the keywords.
    typedef enum logic [qtl_pkg::KIND_W-1:0] {
        KW_ENTITIES = 5'd9,
        KW_HAS_ANY,
        KW_NOT_HAS,
        KW_SELECT,
        KW_ENTITY,
        KW_COUNT,
        KW_WHERE,
        KW_SHOW,
        KW_HAS,
        KW_ALL,
        KW_AND,
        KW_OF,
        KW_OR
    } keyword_kind_e;

    localparam logic [qtl_pkg::CHAR_W-1:0] NEWLINE = 8'd10;

    // The tracker keeps its own copy of the lexer state. Each accepted input
    // item is scanned here and the tokens it gives are queued in order; every
    // token that leaves the block is then matched against the oldest one.
    class lexer_tracker;
        typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_OPER} scan_mode_e;
        typedef logic [qtl_pkg::POS_BITS-1:0] pos_t;

        scan_mode_e       mode;
        pos_t             start_off;
        pos_t             start_ln;
        pos_t             start_col;
        pos_t             here_off;
        pos_t             here_ln;
        pos_t             here_col;
        pos_t             run_len;
        logic [63:0]      upper_tail;
        qtl_pkg::token_t  due_tokens[$];
        qtl_pkg::token_t  step_tokens[$];
        int               errors;
        int               checked;

        function new();
            restart();
            errors  = 0;
            checked = 0;
        endfunction

        function void restart();
            mode       = SCAN_IDLE;
            start_off  = '0;
            start_ln   = pos_t'(1);
            start_col  = pos_t'(1);
            here_off   = '0;
            here_ln    = pos_t'(1);
            here_col   = pos_t'(1);
            run_len    = '0;
            upper_tail = '0;
        endfunction

        function int pending();
            return due_tokens.size();
        endfunction

        // Counters stop at all ones rather than wrapping.
        function pos_t bump(pos_t v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function bit is_digit(logic [qtl_pkg::CHAR_W-1:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [qtl_pkg::CHAR_W-1:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function logic [qtl_pkg::CHAR_W-1:0] upper(logic [qtl_pkg::CHAR_W-1:0] c);
            return (c >= "a" && c <= "z") ? c - 8'd32 : c;
        endfunction

        function void step_forward();
            here_off = bump(here_off);
            here_col = bump(here_col);
        endfunction

        function void open_token();
            start_off = here_off;
            start_ln  = here_ln;
            start_col = here_col;
            run_len   = pos_t'(1);
        endfunction

        function void add_token(logic [qtl_pkg::KIND_W-1:0] kind, pos_t off, pos_t len,
                                pos_t ln, pos_t col);
            qtl_pkg::token_t t;
            t.kind         = kind;
            t.start_offset = qtl_pkg::FIELD_W'(off);
            t.length       = qtl_pkg::FIELD_W'(len);
            t.line         = qtl_pkg::FIELD_W'(ln);
            t.column       = qtl_pkg::FIELD_W'(col);
            t.last         = 1'b0;
            step_tokens.push_back(t);
        endfunction

        // While an identifier is at most eight bytes long the tail holds all of
        // it, upper-cased and right-aligned, so a plain compare finds keywords.
        function logic [qtl_pkg::KIND_W-1:0] word_kind();
            logic [qtl_pkg::KIND_W-1:0] k;
            k = qtl_pkg::KIND_IDENT;
            if (run_len <= pos_t'(8) && run_len <= pos_t'(qtl_pkg::KEYWORD_CHARS)) begin
                case (upper_tail)
                    64'("ENTITIES"): k = KW_ENTITIES;
                    64'("HAS_ANY"):  k = KW_HAS_ANY;
                    64'("NOT_HAS"):  k = KW_NOT_HAS;
                    64'("SELECT"):   k = KW_SELECT;
                    64'("ENTITY"):   k = KW_ENTITY;
                    64'("COUNT"):    k = KW_COUNT;
                    64'("WHERE"):    k = KW_WHERE;
                    64'("SHOW"):     k = KW_SHOW;
                    64'("HAS"):      k = KW_HAS;
                    64'("ALL"):      k = KW_ALL;
                    64'("AND"):      k = KW_AND;
                    64'("OF"):       k = KW_OF;
                    64'("OR"):       k = KW_OR;
                    default:         k = qtl_pkg::KIND_IDENT;
                endcase
            end
            return k;
        endfunction

        function void flush_pending();
            logic [qtl_pkg::KIND_W-1:0] kind;
            if (mode == SCAN_IDLE)
                return;
            if (mode == SCAN_NUMBER)
                kind = qtl_pkg::KIND_NUMBER;
            else if (mode == SCAN_OPER)
                kind = qtl_pkg::KIND_OPER;
            else
                kind = word_kind();
            add_token(kind, start_off, run_len, start_ln, start_col);
            mode = SCAN_IDLE;
        endfunction

        // A byte seen with no token open.
        function void scan_byte(logic [qtl_pkg::CHAR_W-1:0] c);
            logic [qtl_pkg::KIND_W-1:0] kind;
            if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
                if (c == NEWLINE) begin
                    here_off = bump(here_off);
                    here_ln  = bump(here_ln);
                    here_col = pos_t'(1);
                end else begin
                    step_forward();
                end
                return;
            end
            if (c == ">" || c == "<" || c == "=" || c == "!") begin
                open_token();
                mode = SCAN_OPER;
                step_forward();
                return;
            end
            if (is_digit(c)) begin
                open_token();
                mode = SCAN_NUMBER;
                step_forward();
                return;
            end
            if (is_letter(c) || c == "_") begin
                open_token();
                mode       = SCAN_WORD;
                upper_tail = {56'd0, upper(c)};
                step_forward();
                return;
            end
            case (c)
                "(":     kind = qtl_pkg::KIND_LPAREN;
                ")":     kind = qtl_pkg::KIND_RPAREN;
                ".":     kind = qtl_pkg::KIND_DOT;
                ",":     kind = qtl_pkg::KIND_COMMA;
                default: kind = qtl_pkg::KIND_ERROR;
            endcase
            add_token(kind, here_off, pos_t'(1), here_ln, here_col);
            step_forward();
        endfunction

        function void take_byte(logic f, logic [qtl_pkg::CHAR_W-1:0] c);
            qtl_pkg::token_t t;
            step_tokens.delete();
            if (f == qtl_pkg::FUNC_END) begin
                flush_pending();
                add_token(qtl_pkg::KIND_EOF, here_off, '0, here_ln, here_col);
                restart();
            end else if (mode == SCAN_NUMBER && is_digit(c)) begin
                run_len = bump(run_len);
                step_forward();
            end else if (mode == SCAN_WORD && (is_letter(c) || is_digit(c) || c == "_")) begin
                run_len    = bump(run_len);
                upper_tail = {upper_tail[55:0], upper(c)};
                step_forward();
            end else if (mode == SCAN_OPER && c == "=") begin
                run_len = pos_t'(2);
                step_forward();
                flush_pending();
            end else begin
                flush_pending();
                scan_byte(c);
            end
            if (step_tokens.size() > 0) begin
                t      = step_tokens.pop_back();
                t.last = 1'b1;
                step_tokens.push_back(t);
            end
            foreach (step_tokens[i])
                due_tokens.push_back(step_tokens[i]);
        endfunction

        function void field_ok(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void match_token(qtl_pkg::token_t got);
            qtl_pkg::token_t want;
            if (due_tokens.size() == 0) begin
                $error("token with none due: kind %0d at offset %0d",
                       got.kind, got.start_offset);
                errors++;
                return;
            end
            want = due_tokens.pop_front();
            checked++;
            field_ok("token_kind", want.kind, got.kind);
            field_ok("start_offset", want.start_offset, got.start_offset);
            field_ok("token_length", want.length, got.length);
            field_ok("start_line", want.line, got.line);
            field_ok("start_column", want.column, got.column);
            field_ok("last", want.last, got.last);
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           func = qtl_pkg::FUNC_CHAR;
    logic [qtl_pkg::CHAR_W-1:0]     ch = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [qtl_pkg::KIND_W-1:0]     token_kind;
    logic [qtl_pkg::FIELD_W-1:0]    start_offset;
    logic [qtl_pkg::FIELD_W-1:0]    token_length;
    logic [qtl_pkg::FIELD_W-1:0]    start_line;
    logic [qtl_pkg::FIELD_W-1:0]    start_column;
    logic                           last;

    lexer_tracker lexer_track = new();
    bit           idling_on = 1'b1;
    int           sent_items = 0;
    logic [1:0]   stall_left = '0;

    string keywords [13] = '{"ENTITIES", "HAS_ANY", "NOT_HAS", "SELECT", "ENTITY", "COUNT",
                             "WHERE", "SHOW", "HAS", "ALL", "AND", "OF", "OR"};

    query_token_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_offset (start_offset),
        .token_length (token_length),
        .start_line   (start_line),
        .start_column (start_column),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls in random bursts while idling is on. out_stall gets
    // exactly one assignment per edge, the burst counter at most one.
    always @(posedge clk)
    begin
        if (!idling_on) begin
            stall_left <= '0;
            out_stall  <= 1'b0;
        end else if (stall_left != 2'd0) begin
            stall_left <= stall_left - 2'd1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= 2'($urandom_range(0, 2));
            out_stall  <= 1'b1;
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // Both channels are sampled at the clock edge, before any of this edge's
    // nonblocking updates land. Tokens are matched before the input is noted;
    // a token can never leave in the same cycle its item was taken.
    always @(posedge clk)
    begin
        qtl_pkg::token_t got;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got.kind         = token_kind;
                got.start_offset = start_offset;
                got.length       = token_length;
                got.line         = start_line;
                got.column       = start_column;
                got.last         = last;
                lexer_track.match_token(got);
            end
            if (in_valid && !in_stall)
                lexer_track.take_byte(func, ch);
        end
    end

    // Offers one item and returns at the edge that takes it. While idling is
    // on, valid drops for a short burst now and then before the item is shown.
    task automatic send_item(input logic f, input logic [qtl_pkg::CHAR_W-1:0] c);
        if (idling_on && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        ch       <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(qtl_pkg::FUNC_CHAR, s[i]);
    endtask

    // Holds the sender off until every token due so far has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (lexer_track.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [qtl_pkg::CHAR_W-1:0] word_char(input bit lead);
        int pick;
        pick = $urandom_range(0, lead ? 2 : 3);
        case (pick)
            0:       return 8'("A") + 8'($urandom_range(0, 25));
            1:       return 8'("a") + 8'($urandom_range(0, 25));
            2:       return 8'("_");
            default: return 8'("0") + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // One query: mostly a run of well-formed pieces (keywords in mixed case,
    // identifiers, numbers, punctuation, operators, whitespace) that sometimes
    // touch each other so one run breaks another, with stray and high bytes
    // mixed in. About one query in eight is plain noise. Every query ends with
    // the end marker, whose byte is random since the block ignores it.
    task automatic send_query();
        int                           pieces;
        int                           n;
        logic [qtl_pkg::CHAR_W-1:0]   c;
        string                        word;
        string                        punct;
        string                        ops;
        punct  = "().,";
        ops    = "<>=!";
        pieces = $urandom_range(1, 10);
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10))
                send_item(qtl_pkg::FUNC_CHAR, 8'($urandom_range(0, 255)));
        end else begin
            repeat (pieces) begin
                case ($urandom_range(0, 10))
                    0, 1: begin
                        word = keywords[$urandom_range(0, 12)];
                        for (int i = 0; i < word.len(); i++) begin
                            c = word[i];
                            if (c != "_" && $urandom_range(0, 1) == 1)
                                c = c + 8'd32;
                            send_item(qtl_pkg::FUNC_CHAR, c);
                        end
                        // A trailing byte turns the keyword into a plain
                        // identifier; after ENTITIES it is nine bytes long.
                        if ($urandom_range(0, 3) == 0)
                            send_item(qtl_pkg::FUNC_CHAR, word_char(1'b0));
                    end
                    2, 3: begin
                        n = $urandom_range(1, 12);
                        send_item(qtl_pkg::FUNC_CHAR, word_char(1'b1));
                        repeat (n - 1)
                            send_item(qtl_pkg::FUNC_CHAR, word_char(1'b0));
                    end
                    4: begin
                        repeat ($urandom_range(1, 6))
                            send_item(qtl_pkg::FUNC_CHAR,
                                      8'("0") + 8'($urandom_range(0, 9)));
                    end
                    5: send_item(qtl_pkg::FUNC_CHAR, punct[$urandom_range(0, 3)]);
                    6: begin
                        send_item(qtl_pkg::FUNC_CHAR, ops[$urandom_range(0, 3)]);
                        if ($urandom_range(0, 1) == 1)
                            send_item(qtl_pkg::FUNC_CHAR, "=");
                    end
                    7, 8: begin
                        repeat ($urandom_range(1, 3)) begin
                            n = $urandom_range(8, 13);
                            send_item(qtl_pkg::FUNC_CHAR, (n == 8) ? 8'd32 : 8'(n));
                        end
                    end
                    9:       send_item(qtl_pkg::FUNC_CHAR, 8'($urandom_range(0, 255)));
                    default: send_item(qtl_pkg::FUNC_CHAR, 8'($urandom_range(128, 255)));
                endcase
                if ($urandom_range(0, 1) == 0)
                    send_item(qtl_pkg::FUNC_CHAR, " ");
            end
        end
        send_item(qtl_pkg::FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int last_goal;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text: a lower-case keyword, a number broken by a paren,
        // an operator with its '=', a bare '!' followed by '<' and '(' so two
        // tokens leave at once, a high byte, an identifier broken by a dot,
        // every whitespace byte with the newline among them, a token still
        // open at the end marker, and then an empty query.
        send_text("or 42(>=!<(");
        send_item(qtl_pkg::FUNC_CHAR, 8'hFF);
        send_text("x_9.\n\t\r");
        send_item(qtl_pkg::FUNC_CHAR, 8'h0B);
        send_item(qtl_pkg::FUNC_CHAR, 8'h0C);
        send_text(" z");
        send_item(qtl_pkg::FUNC_END, 8'h00);
        send_item(qtl_pkg::FUNC_END, 8'hFF);
        wait_for_results();

        while (sent_items < 450)
            send_query();
        wait_for_results();

        // From here on neither side idles, so items and tokens go back to back.
        idling_on = 1'b0;
        last_goal = sent_items + 150;
        while (sent_items < last_goal)
            send_query();

        in_valid <= 1'b0;
        @(posedge clk);
        while (lexer_track.pending() != 0)
            @(posedge clk);
        // Trailing bytes of a word or number give no token, so keep watching the
        // output for anything stray before the summary.
        repeat (10) @(posedge clk);

        $display("Sent %0d input items and checked %0d tokens: keywords, operators,",
                 sent_items, lexer_track.checked);
        $display("run breaks, error bytes, paired tokens and stalls on both sides.");
        if (lexer_track.errors == 0 && lexer_track.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
